[hdl/summed_area_rect_sum_defines.svh]
// assertion macros of the summed-area block, used by its back end
`ifndef SUMMED_AREA_RECT_SUM_DEFINES_SVH
`define SUMMED_AREA_RECT_SUM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SARS_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sars assertion failed");

// next-cycle implication, checked outside reset
`define SARS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sars assertion failed");

`endif

[hdl/sars_pkg.sv]
// types, constants and codes of the summed-area rectangle sum block
package sars_pkg;

  localparam int MAX_SIDE      = 64;
  localparam int ELEMENT_WIDTH = 16;
  localparam int COORD_W       = $clog2(MAX_SIDE);
  localparam int SIDE_W        = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W        = 2 * COORD_W;
  localparam int TABLE_DEPTH   = 1 << ADDR_W;
  localparam int TABLE_W       = 28;
  localparam int RUN_W         = 22;
  localparam int CFG_W         = 7;
  localparam int GRID_RESET    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QUERY_READS   = 4;
  localparam int STEP_W        = $clog2(QUERY_READS + 1);
  localparam int PADDR_W       = 3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_COORD = 2'd1;
  localparam logic [1:0] STATUS_NOT_FULL  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_GRID_SIDE = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic signed [15:0] element_value;
    logic [5:0]        top_row;
    logic [5:0]        left_col;
    logic [5:0]        bottom_row;
    logic [5:0]        right_col;
  } in_item_t;

  typedef struct packed {
    logic signed [27:0] rect_sum;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_REPORT
  } cmd_kind_t;

  // load: bottom_row/right_col hold the load position
  typedef struct packed {
    cmd_kind_t               kind;
    logic [1:0]              status;
    logic [COORD_W-1:0]      top_row;
    logic [COORD_W-1:0]      left_col;
    logic [COORD_W-1:0]      bottom_row;
    logic [COORD_W-1:0]      right_col;
    logic signed [RUN_W-1:0] run_sum;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD_RD,
    B_LOAD_WR,
    B_QUERY
  } back_state_t;

endpackage

[hdl/sars_ram.sv]
// generic single-port ram with registered read
module sars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hdl/sars_front.sv]
// front end: tracks the load position and classifies each accepted item
module sars_front
  import sars_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_item_t         item,
  input  logic [CFG_W-1:0] grid_side,
  input  logic             cfg_restart,
  output cmd_t             cmd
);

  logic [COORD_W-1:0]      load_row, load_row_next;
  logic [COORD_W-1:0]      load_col, load_col_next;
  logic signed [RUN_W-1:0] run_sum, run_sum_next;
  logic                    table_full, table_full_next;

  logic [SIDE_W-1:0]       side;
  logic [COORD_W-1:0]      row_base, col_base;
  logic signed [RUN_W-1:0] run_base, run_new;
  logic                    restart;
  logic [SIDE_W-1:0]       col_inc, row_inc;
  logic [COORD_W-1:0]      q_top, q_left, q_bottom, q_right;
  logic                    bad_coord;

  // grid side clamped to 1..MAX_SIDE
  always_comb begin
    if (grid_side == '0) begin
      side = SIDE_W'(1);
    end else if (int'(grid_side) > MAX_SIDE) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_side);
    end
  end

  assign q_top    = item.top_row[COORD_W-1:0];
  assign q_left   = item.left_col[COORD_W-1:0];
  assign q_bottom = item.bottom_row[COORD_W-1:0];
  assign q_right  = item.right_col[COORD_W-1:0];

  assign bad_coord = (SIDE_W'(q_bottom) >= side) || (SIDE_W'(q_right) >= side) ||
                     (q_top > q_bottom) || (q_left > q_right);

  always_comb begin
    restart  = table_full || (SIDE_W'(load_row) >= side) || (SIDE_W'(load_col) >= side);
    row_base = restart ? '0 : load_row;
    col_base = restart ? '0 : load_col;
    run_base = restart ? '0 : run_sum;
    run_new  = run_base + RUN_W'($signed(item.element_value[ELEMENT_WIDTH-1:0]));
    col_inc  = SIDE_W'(col_base) + SIDE_W'(1);
    row_inc  = SIDE_W'(row_base) + SIDE_W'(1);

    load_row_next   = load_row;
    load_col_next   = load_col;
    run_sum_next    = run_sum;
    table_full_next = table_full;

    cmd.kind       = CMD_REPORT;
    cmd.status     = STATUS_OK;
    cmd.top_row    = q_top;
    cmd.left_col   = q_left;
    cmd.bottom_row = q_bottom;
    cmd.right_col  = q_right;
    cmd.run_sum    = run_new;

    if (item.opcode == OP_LOAD) begin
      cmd.kind       = CMD_LOAD;
      cmd.bottom_row = row_base;
      cmd.right_col  = col_base;
      if (accept) begin
        table_full_next = 1'b0;
        if (col_inc >= side) begin
          load_col_next = '0;
          run_sum_next  = '0;
          if (row_inc >= side) begin
            load_row_next   = '0;
            table_full_next = 1'b1;
          end else begin
            load_row_next = row_inc[COORD_W-1:0];
          end
        end else begin
          load_col_next = col_inc[COORD_W-1:0];
          load_row_next = row_base;
          run_sum_next  = run_new;
        end
      end
    end else if (!table_full) begin
      cmd.status = STATUS_NOT_FULL;
    end else if (bad_coord) begin
      cmd.status = STATUS_BAD_COORD;
    end else begin
      cmd.kind = CMD_QUERY;
    end

    if (cfg_restart) begin
      load_row_next   = '0;
      load_col_next   = '0;
      run_sum_next    = '0;
      table_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_row   <= '0;
      load_col   <= '0;
      run_sum    <= '0;
      table_full <= 1'b0;
    end else begin
      load_row   <= load_row_next;
      load_col   <= load_col_next;
      run_sum    <= run_sum_next;
      table_full <= table_full_next;
    end
  end

endmodule

[hdl/sars_queue.sv]
// short command queue between front and back end
module sars_queue
  import sars_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cmd_t        push_cmd,
  input  logic        pop,
  output cmd_t        head,
  output queue_stat_t stat
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/sars_back.sv]
// back end: runs loads and queries against the table memory
`include "summed_area_rect_sum_defines.svh"

module sars_back
  import sars_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  queue_stat_t q_stat,
  output logic        pop,
  output logic        done,
  output result_t     result
);

  back_state_t         state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  cmd_t                cur, cur_next;
  logic [TABLE_W-1:0]  acc, acc_next;
  logic                done_next;
  result_t             result_next;

  logic                ram_en;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [TABLE_W-1:0]  ram_wdata;
  logic [TABLE_W-1:0]  ram_rdata;

  logic [1:0]          term_idx;
  logic                term_use;
  logic [TABLE_W-1:0]  term;
  logic [COORD_W-1:0]  top_m1, left_m1;

  sars_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign top_m1  = cur.top_row - COORD_W'(1);
  assign left_m1 = cur.left_col - COORD_W'(1);

  // term k of the query is read back while step holds k + 1
  always_comb begin
    term_idx = 2'(step - STEP_W'(1));
    case (term_idx)
      2'd0:    term_use = 1'b1;
      2'd1:    term_use = (cur.top_row != '0);
      2'd2:    term_use = (cur.left_col != '0);
      default: term_use = (cur.top_row != '0) && (cur.left_col != '0);
    endcase
    term = term_use ? ram_rdata : '0;
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    cur_next    = cur;
    acc_next    = acc;
    done_next   = 1'b0;
    result_next = result;
    pop         = 1'b0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = {cur.bottom_row, cur.right_col};
    ram_wdata   = '0;

    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          cur_next = head;
          case (head.kind)
            CMD_LOAD: begin
              state_next = B_LOAD_RD;
            end
            CMD_QUERY: begin
              state_next = B_QUERY;
              step_next  = '0;
              acc_next   = '0;
            end
            default: begin
              done_next   = 1'b1;
              result_next = '{rect_sum: '0, status: head.status};
            end
          endcase
        end
      end
      B_LOAD_RD: begin
        ram_en     = 1'b1;
        ram_addr   = {cur.bottom_row - COORD_W'(1), cur.right_col};
        state_next = B_LOAD_WR;
      end
      B_LOAD_WR: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_wdata  = ((cur.bottom_row != '0) ? ram_rdata : '0) +
                     TABLE_W'(cur.run_sum);
        state_next = B_IDLE;
      end
      B_QUERY: begin
        if (step != STEP_W'(QUERY_READS)) begin
          ram_en = 1'b1;
          case (step[1:0])
            2'd0:    ram_addr = {cur.bottom_row, cur.right_col};
            2'd1:    ram_addr = {top_m1, cur.right_col};
            2'd2:    ram_addr = {cur.bottom_row, left_m1};
            default: ram_addr = {top_m1, left_m1};
          endcase
        end
        if (step != '0) begin
          if (term_idx == 2'd1 || term_idx == 2'd2) begin
            acc_next = acc - term;
          end else begin
            acc_next = acc + term;
          end
        end
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(QUERY_READS)) begin
          done_next   = 1'b1;
          result_next = '{rect_sum: acc_next, status: STATUS_OK};
          state_next  = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step   <= step_next;
    cur    <= cur_next;
    acc    <= acc_next;
    result <= result_next;
  end

  `SARS_ASSERT_NEXT(a_load_write, clk, rst, state == B_LOAD_RD, state == B_LOAD_WR)
  `SARS_ASSERT(a_sum_zero, clk, rst, done, result.status == STATUS_OK || result.rect_sum == '0)
  `SARS_ASSERT(a_pop_nonempty, clk, rst, pop, !q_stat.empty)
  `SARS_ASSERT(a_pop_idle, clk, rst, state != B_IDLE, !pop)

endmodule

[hdl/summed_area_rect_sum.sv]
// top level of the summed-area table with rectangle sum queries
// usage:
//   items come in on item with start; one is taken at each edge where start
//   is high and busy is low. opcode 0 loads the next grid element in raster
//   order, opcode 1 asks for an inclusive rectangle sum.
//   a query gives one result on result, marked by done for exactly one cycle;
//   a load gives none. the receiver cannot hold results off.
//   grid_side is written over the apb port at byte address 0 while the block
//   is idle; a write restarts loading at element (0,0).
// timing:
//   a four-entry command queue parts the front end from the table engine.
//   the single-port table memory sets the pace, and the engine finishes one
//   command before it pops the next: a load is a pop, a read of the cell
//   above and a write; an in-range query is a pop, four reads and the final
//   sum; a query that fails its checks is only a pop, its result registered
//   from the queue head. busy rises while the queue is full.
// reset:
//   rst clears the queue, the load position and the full flag, and sets
//   grid_side to 64; the table memory holds no reset value and needs no
//   clearing pass.
module summed_area_rect_sum
  import sars_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CFG_W-1:0] grid_side;
  logic             cfg_write;
  logic             accept;
  cmd_t             push_cmd;
  cmd_t             head;
  queue_stat_t      q_stat;
  logic             pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_GRID_SIDE);
  assign prdata    = (paddr[2] == REG_GRID_SIDE) ? 32'(grid_side) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= CFG_W'(GRID_RESET);
    end else if (cfg_write) begin
      grid_side <= pwdata[CFG_W-1:0];
    end
  end

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  sars_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .grid_side   (grid_side),
    .cfg_restart (cfg_write),
    .cmd         (push_cmd)
  );

  sars_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sars_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

[sim/testbench.sv]
// testbench for the summed-area rectangle sum block: directed and random tables and queries
module testbench;
  import sars_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 420;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           item = '0;
  logic               done;
  result_t            result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  logic signed [TABLE_W-1:0] sat_table [0:MAX_SIDE*MAX_SIDE-1];
  int unsigned               fill_row;
  int unsigned               fill_col;
  logic [RUN_W-1:0]          row_acc;
  bit                        table_ready;
  logic [CFG_W-1:0]          side_reg;

  result_t sums_due [$];
  int      errors = 0;
  int      items_sent = 0;
  bit      no_gaps = 1'b0;

  summed_area_rect_sum i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("summed_area_rect_sum verification failed");
    $finish;
  end

  function automatic int unsigned side_now();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic int unsigned cell_index(input int unsigned r, input int unsigned c);
    return r * MAX_SIDE + c;
  endfunction

  function automatic void restart_fill();
    fill_row = 0;
    fill_col = 0;
    row_acc = '0;
    table_ready = 1'b0;
  endfunction

  // expected result of one accepted item, pushed when the item is a query
  function automatic void predict_sum(input in_item_t it);
    int unsigned               side;
    logic signed [RUN_W-1:0]   run;
    logic signed [TABLE_W-1:0] above;
    logic signed [TABLE_W-1:0] acc;
    result_t                   res;
    side = side_now();
    if (it.opcode == OP_LOAD) begin
      if (table_ready || fill_row >= side || fill_col >= side) restart_fill();
      row_acc = row_acc + RUN_W'(it.element_value);
      run = row_acc;
      above = (fill_row > 0) ? sat_table[cell_index(fill_row - 1, fill_col)] : '0;
      sat_table[cell_index(fill_row, fill_col)] = above + TABLE_W'(run);
      fill_col++;
      if (fill_col >= side) begin
        fill_col = 0;
        row_acc = '0;
        fill_row++;
        if (fill_row >= side) begin
          fill_row = 0;
          table_ready = 1'b1;
        end
      end
    end else begin
      res.rect_sum = '0;
      if (!table_ready) begin
        res.status = STATUS_NOT_FULL;
      end else if (it.bottom_row >= side || it.right_col >= side ||
                   it.top_row > it.bottom_row || it.left_col > it.right_col) begin
        res.status = STATUS_BAD_COORD;
      end else begin
        acc = sat_table[cell_index(it.bottom_row, it.right_col)];
        if (it.top_row > 0)
          acc = acc - sat_table[cell_index(it.top_row - 1, it.right_col)];
        if (it.left_col > 0)
          acc = acc - sat_table[cell_index(it.bottom_row, it.left_col - 1)];
        if (it.top_row > 0 && it.left_col > 0)
          acc = acc + sat_table[cell_index(it.top_row - 1, it.left_col - 1)];
        res.rect_sum = acc;
        res.status = STATUS_OK;
      end
      sums_due.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (sums_due.size() == 0) begin
        $display("%0t: result with none expected, actual sum %0d status %0d",
                 $time, result.rect_sum, result.status);
        errors++;
      end else begin
        want = sums_due.pop_front();
        if (result.rect_sum !== want.rect_sum) begin
          $display("%0t: rect_sum mismatch, expected %0d, actual %0d",
                   $time, want.rect_sum, result.rect_sum);
          errors++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, result.status);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (no_gaps) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ELEMENT_WIDTH-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    predict_sum(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic signed [ELEMENT_WIDTH-1:0] v);
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.opcode = OP_LOAD;
    it.element_value = v;
    send_item(it);
  endtask

  task automatic send_query(input int unsigned t, input int unsigned l,
                            input int unsigned b, input int unsigned r);
    in_item_t it;
    it.opcode = OP_QUERY;
    it.element_value = 16'($urandom);
    it.top_row = 6'(t);
    it.left_col = 6'(l);
    it.bottom_row = 6'(b);
    it.right_col = 6'(r);
    send_item(it);
  endtask

  // mostly in-range rectangles, the rest anywhere in the coordinate space
  task automatic send_rand_query();
    int unsigned side;
    int unsigned t;
    int unsigned l;
    side = side_now();
    if ($urandom_range(0, 99) < 80) begin
      t = $urandom_range(0, side - 1);
      l = $urandom_range(0, side - 1);
      send_query(t, l, $urandom_range(t, side - 1), $urandom_range(l, side - 1));
    end else begin
      send_query($urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  // loads leave no result behind, so give the engine time to finish them
  task automatic wait_drained();
    start <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_side(input logic [CFG_W-1:0] v);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(REG_GRID_SIDE));
    pwdata <= {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_reg = v;
    restart_fill();
    @(posedge clk);
  endtask

  task automatic test_not_full_after_reset();
    send_query(0, 0, 0, 0);
    send_query(63, 63, 63, 63);
    send_load(16'sh1234);
    send_query(0, 0, 0, 0);
  endtask

  task automatic test_two_by_two_corners();
    write_grid_side(7'd2);
    send_load(16'sh7fff);
    send_load(16'sh8000);
    send_query(0, 0, 1, 1);
    send_load(16'shffff);
    send_load(16'sh0001);
    send_query(0, 0, 1, 1);
    send_query(1, 1, 1, 1);
    send_query(0, 1, 1, 1);
    send_query(1, 0, 1, 0);
    send_query(0, 0, 0, 1);
    send_query(0, 0, 2, 1);
    send_query(0, 0, 1, 63);
    send_query(1, 0, 0, 0);
    send_query(0, 1, 0, 0);
    send_query(63, 63, 63, 63);
  endtask

  task automatic test_reload_after_full();
    // a load on a full table starts element (0,0) of a new one
    send_load(16'sh0005);
    send_query(0, 0, 0, 0);
    send_load(16'sh8000);
    send_load(16'sh7fff);
    send_load(16'sh0000);
    send_query(0, 0, 1, 1);
  endtask

  task automatic test_side_clamp_low();
    write_grid_side(7'd0);
    send_load(16'sh8000);
    send_query(0, 0, 0, 0);
    send_query(0, 0, 1, 1);
    write_grid_side(7'd1);
    send_load(16'sh7fff);
    send_query(0, 0, 0, 0);
  endtask

  task automatic test_side_rewrite_mid_load();
    write_grid_side(7'd3);
    repeat (4) send_load(rand_elem());
    write_grid_side(7'd3);
    repeat (8) send_load(rand_elem());
    send_query(0, 0, 2, 2);
    send_load(rand_elem());
    send_query(1, 1, 2, 2);
    send_query(0, 0, 2, 2);
  endtask

  task automatic test_full_grid_extremes();
    no_gaps = 1'b1;
    write_grid_side(7'd16);
    repeat (16 * 16) send_load(16'sh8000);
    no_gaps = 1'b0;
    send_query(0, 0, 15, 15);
    send_query(15, 15, 15, 15);
    repeat (10) send_rand_query();
    // above the maximum side acts as the maximum side
    write_grid_side(7'd127);
    repeat (MAX_SIDE + 3) send_load(16'sh7fff);
    send_query(0, 0, 0, 0);
    send_query(0, 0, 63, 63);
  endtask

  task automatic test_random_tables();
    int          base;
    int unsigned p;
    int unsigned cells;
    int unsigned stop_at;
    int unsigned nq;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (!table_ready || $urandom_range(0, 2) != 0) begin
        p = $urandom_range(0, 99);
        if (p < 4) write_grid_side(7'd0);
        else if (p < 75) write_grid_side(7'($urandom_range(1, 6)));
        else write_grid_side(7'($urandom_range(7, 16)));
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      cells = side_now() * side_now();
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cells - 1) : cells;
      for (int unsigned i = 0; i < stop_at; i++) begin
        if ($urandom_range(0, 19) == 0) send_rand_query();
        send_load(rand_elem());
      end
      nq = $urandom_range(4, 24);
      for (int unsigned j = 0; j < nq; j++) begin
        if ($urandom_range(0, 29) == 0) send_load(rand_elem());
        send_rand_query();
      end
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    restart_fill();
    side_reg = 7'(GRID_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_not_full_after_reset();
    test_two_by_two_corners();
    test_reload_after_full();
    test_side_clamp_low();
    test_side_rewrite_mid_load();
    test_full_grid_extremes();
    test_random_tables();
    wait_drained();
    if (errors == 0 && sums_due.size() == 0) begin
      $display("summed_area_rect_sum verification clean");
    end else begin
      $display("summed_area_rect_sum verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sars_pkg.sv
hdl/sars_ram.sv
hdl/sars_front.sv
hdl/sars_queue.sv
hdl/sars_back.sv
hdl/summed_area_rect_sum.sv
sim/testbench.sv
